### src/bcf_pkg.sv
// ----------------------------------------------------------------------------
// bcf_pkg: shared types and constants for the binary confusion / f1 block
// sample and metric beat layouts, field widths and the default batch limit
// ----------------------------------------------------------------------------
package bcf_pkg;

	localparam int CNT_W     = 15;
	localparam int RATIO_W   = 17;
	localparam int MAX_BATCH = 32767;

	typedef struct packed {
		logic signed [31:0] prediction;
		logic [7:0]         label;
		logic               last_item;
	} bcf_sample_t;

	typedef struct packed {
		logic [CNT_W-1:0]   true_pos;
		logic [CNT_W-1:0]   false_pos;
		logic [CNT_W-1:0]   true_neg;
		logic [CNT_W-1:0]   false_neg;
		logic [RATIO_W-1:0] accuracy;
		logic [RATIO_W-1:0] precision;
		logic [RATIO_W-1:0] recall;
		logic [RATIO_W-1:0] f1_score;
	} bcf_metric_t;

endpackage

### src/binary_confusion_f1.sv
// ----------------------------------------------------------------------------
// binary_confusion_f1: streaming binary confusion matrix with f1 score
// counts tp/fp/tn/fn per batch and reports four q1.16 ratios on the last beat
// ----------------------------------------------------------------------------
// A sample beat that is not marked last bumps one of four saturating counters
// and leaves the block ready for the next beat. A beat marked last is counted,
// then the block drops sample_ready while one shared restoring divider (17
// iterations per quotient, each after a setup state) produces accuracy,
// precision and recall, a single 17x17 multiply forms precision*recall, and
// the divider runs once more for f1. The finished
// metric beat sits in an output register, so sample beats of the next batch are
// accepted while it waits for metric_ready; a second last beat arriving before
// the first metric beat has been taken holds in the final step until it is.
// Counters clear when the metric beat is loaded into the output register.
// Each counter stops at MAX_BATCH; a zero denominator gives a zero ratio.
module binary_confusion_f1 #(
	parameter int MAX_BATCH = bcf_pkg::MAX_BATCH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  bcf_pkg::bcf_sample_t sample,
	output logic                 metric_valid,
	input  logic                 metric_ready,
	output bcf_pkg::bcf_metric_t metric
);
	import bcf_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;  // set up divider for the current ratio
	localparam logic [2:0] ST_DIV  = 3'd2;  // one quotient bit per cycle
	localparam logic [2:0] ST_MUL  = 3'd3;  // precision * recall
	localparam logic [2:0] ST_DONE = 3'd4;  // hand result to output register

	// ratio being computed
	localparam logic [1:0] OP_ACC  = 2'd0;
	localparam logic [1:0] OP_PREC = 2'd1;
	localparam logic [1:0] OP_REC  = 2'd2;
	localparam logic [1:0] OP_F1   = 2'd3;

	localparam int OPND_W    = RATIO_W + 1;  // numerator / denominator width
	localparam int STEP_W    = $clog2(RATIO_W);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BATCH);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RATIO_W - 1);

	logic [2:0]  state_q;
	logic [1:0]  op_q;

	// batch counters
	logic [CNT_W-1:0] tp_q, fp_q, tn_q, fn_q;

	// divider
	logic [OPND_W-1:0] den_q;
	logic [OPND_W-1:0] rem_q;
	logic [RATIO_W-1:0] quo_q;
	logic              lsb_q;
	logic              zero_q;
	logic [STEP_W-1:0] step_q;

	// ratio results
	logic [RATIO_W-1:0] acc_q, prec_q, rec_q, f1_q;
	logic [OPND_W-1:0]  pr2_q;

	// output register
	logic        out_valid_q;
	bcf_metric_t out_q;

	logic sample_acc;
	logic pred_pos, lab_pos;
	logic out_load;

	logic [OPND_W-1:0] div_num, div_den;
	logic              shift_bit;
	logic [OPND_W+1:0] trial;
	logic              fits;
	logic [RATIO_W-1:0] div_res;
	logic [2*RATIO_W-1:0] prod;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c >= CNT_MAX) begin
			r = CNT_MAX;
		end else begin
			r = c + 1'b1;
		end
		return r;
	endfunction

	assign sample_ready = (state_q == ST_IDLE);
	assign sample_acc   = sample_valid && sample_ready;

	// prediction of zero or below is negative, any nonzero label byte is positive
	assign pred_pos = !sample.prediction[31] && (sample.prediction != '0);
	assign lab_pos  = (sample.label != '0);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || metric_ready);

	// operand select for the shared divider
	always_comb begin
		case (op_q)
			OP_ACC: begin
				div_num = OPND_W'({1'b0, tp_q} + {1'b0, tn_q});
				div_den = OPND_W'({2'b0, tp_q} + {2'b0, fp_q} + {2'b0, tn_q} + {2'b0, fn_q});
			end
			OP_PREC: begin
				div_num = OPND_W'(tp_q);
				div_den = OPND_W'({1'b0, tp_q} + {1'b0, fp_q});
			end
			OP_REC: begin
				div_num = OPND_W'(tp_q);
				div_den = OPND_W'({1'b0, tp_q} + {1'b0, fn_q});
			end
			default: begin
				div_num = pr2_q;
				div_den = {1'b0, prec_q} + {1'b0, rec_q};
			end
		endcase
	end

	// numerator is num << 16 and the quotient fits in 17 bits, so the divider
	// starts from num >> 1 and shifts in num[0] followed by zeros
	assign shift_bit = (step_q == '0) ? lsb_q : 1'b0;
	assign trial     = {1'b0, rem_q, shift_bit} - {2'b0, den_q};
	assign fits      = !trial[OPND_W+1];
	assign div_res   = zero_q ? '0 : {quo_q[RATIO_W-2:0], fits};

	assign prod = prec_q * rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_ACC;
			tp_q        <= '0;
			fp_q        <= '0;
			tn_q        <= '0;
			fn_q        <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new metric beat may replace one taken in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (metric_valid && metric_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_acc) begin
						if (pred_pos && lab_pos) begin
							tp_q <= sat_inc(tp_q);
						end else if (pred_pos) begin
							fp_q <= sat_inc(fp_q);
						end else if (!lab_pos) begin
							tn_q <= sat_inc(tn_q);
						end else begin
							fn_q <= sat_inc(fn_q);
						end
						if (sample.last_item) begin
							state_q <= ST_LOAD;
							op_q    <= OP_ACC;
						end
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						case (op_q)
							OP_ACC:  state_q <= ST_LOAD;
							OP_PREC: state_q <= ST_LOAD;
							OP_REC:  state_q <= ST_MUL;
							default: state_q <= ST_DONE;
						endcase
						if (op_q != OP_F1) begin
							op_q <= op_q + 1'b1;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_LOAD;
				end
				ST_DONE: begin
					if (out_load) begin
						tp_q        <= '0;
						fp_q        <= '0;
						tn_q        <= '0;
						fn_q        <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				den_q  <= div_den;
				rem_q  <= div_num >> 1;
				lsb_q  <= div_num[0];
				zero_q <= (div_den == '0);
				quo_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= fits ? trial[OPND_W-1:0] : {rem_q[OPND_W-2:0], shift_bit};
				quo_q <= {quo_q[RATIO_W-2:0], fits};
				if (step_q == LAST_STEP) begin
					case (op_q)
						OP_ACC:  acc_q  <= div_res;
						OP_PREC: prec_q <= div_res;
						OP_REC:  rec_q  <= div_res;
						default: f1_q   <= div_res;
					endcase
				end
			end
			ST_MUL: begin
				// product of two ratios <= 1.0 keeps bit 33 clear
				pr2_q <= {prod[2*RATIO_W-2:RATIO_W-1], 1'b0};
			end
			ST_DONE: begin
				if (out_load) begin
					out_q.true_pos  <= tp_q;
					out_q.false_pos <= fp_q;
					out_q.true_neg  <= tn_q;
					out_q.false_neg <= fn_q;
					out_q.accuracy  <= acc_q;
					out_q.precision <= prec_q;
					out_q.recall    <= rec_q;
					out_q.f1_score  <= f1_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign metric_valid = out_valid_q;
	assign metric       = out_q;

endmodule

### src/bcf_checker.sv
// ----------------------------------------------------------------------------
// bcf_checker: port-level checks for binary_confusion_f1
// watches sample and metric beats and the ranges of reported ratios
// ----------------------------------------------------------------------------
module bcf_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 sample_valid,
	input logic                 sample_ready,
	input bcf_pkg::bcf_sample_t sample,
	input logic                 metric_valid,
	input logic                 metric_ready,
	input bcf_pkg::bcf_metric_t metric
);
	import bcf_pkg::*;

	localparam logic [RATIO_W-1:0] ONE_Q16 = RATIO_W'(65536);

	// a last beat starts the metric pass, so the block stalls input next cycle
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && sample.last_item |=> !sample_ready)
		else $error("sample_ready high right after a last beat");

	// a stalled metric beat holds
	a_metric_hold: assert property (@(posedge clk) disable iff (!arst_n)
		metric_valid && !metric_ready |=> metric_valid && $stable(metric))
		else $error("metric beat changed while stalled");

	// ratios never exceed one
	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		metric_valid |-> metric.accuracy <= ONE_Q16 && metric.precision <= ONE_Q16
			&& metric.recall <= ONE_Q16 && metric.f1_score <= ONE_Q16)
		else $error("ratio above one");

	// no true positives means zero precision, recall and f1
	a_no_tp: assert property (@(posedge clk) disable iff (!arst_n)
		metric_valid && metric.true_pos == '0 |->
			metric.precision == '0 && metric.recall == '0 && metric.f1_score == '0)
		else $error("nonzero ratio without true positives");

	// every batch holds at least its last sample
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		metric_valid |-> (metric.true_pos != '0 || metric.false_pos != '0
			|| metric.true_neg != '0 || metric.false_neg != '0))
		else $error("metric beat for an empty batch");

endmodule

bind binary_confusion_f1 bcf_checker u_bcf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.sample       (sample),
	.metric_valid (metric_valid),
	.metric_ready (metric_ready),
	.metric       (metric)
);
